>>> hdl/scpc_pkg.sv
// scpc_pkg: shared types, constants and response codes for the serial command pulse counter
// no dependencies
package scpc_pkg;

  localparam int LINE_LENGTH = 20;
  localparam int KEPT = 8;
  localparam int IDX_W = 5;

  localparam logic [2:0] RSP_NONE  = 3'd0;
  localparam logic [2:0] RSP_START = 3'd1;
  localparam logic [2:0] RSP_STOP  = 3'd2;
  localparam logic [2:0] RSP_M1    = 3'd3;
  localparam logic [2:0] RSP_M2    = 3'd4;
  localparam logic [2:0] RSP_ERR   = 3'd5;
  localparam logic [2:0] RSP_OVF   = 3'd6;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_pin;
    logic       pulse;
    logic       turn;
    logic [2:0] kind;      // parse outcome, RSP_NONE when no parse
    logic [7:0] value;     // mode 2 target
  } scpc_op_t;

endpackage

>>> hdl/scpc_front.sv
// scpc_front: line buffer and command parser, emits classified requests
// depends on scpc_pkg
module scpc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [7:0]          rx_byte,
  input  logic                pulse_pin,
  input  logic                turn_pin,
  output logic                op_valid,
  input  logic                op_stall,
  output scpc_pkg::scpc_op_t  op
);

  logic [7:0] line [scpc_pkg::KEPT];
  logic [scpc_pkg::IDX_W-1:0] write_index;
  logic [scpc_pkg::IDX_W-1:0] widx;
  logic [7:0] cur [scpc_pkg::KEPT];
  logic       accept;
  scpc_pkg::scpc_op_t op_next;

  assign in_stall = op_stall;
  assign accept   = in_valid && !op_stall;

  // line view with the current byte written in
  always_comb begin
    widx = (rx_byte == scpc_pkg::CH_OPEN) ? '0 : write_index;
    for (int i = 0; i < scpc_pkg::KEPT; i++) begin
      cur[i] = line[i];
      if (widx == scpc_pkg::IDX_W'(i)) cur[i] = rx_byte;
    end
  end

  // parse the line
  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= 8'd48) && (c <= 8'd57);
  endfunction

  always_comb begin
    logic [9:0] val;
    logic       ok;
    logic [1:0] len;
    val = '0;
    ok  = 1'b1;
    len = 2'd0;
    op_next = '0;
    op_next.is_pin = func;
    op_next.pulse  = pulse_pin;
    op_next.turn   = turn_pin;
    op_next.kind   = scpc_pkg::RSP_NONE;
    if (!func && rx_byte == scpc_pkg::CH_CLOSE) begin
      if (cur[0] == "(" && cur[1] == "S" && cur[2] == "T" && cur[3] == "A" &&
          cur[4] == "R" && cur[5] == "T" && cur[6] == ")")
        op_next.kind = scpc_pkg::RSP_START;
      else if (cur[0] == "(" && cur[1] == "S" && cur[2] == "T" && cur[3] == "O" &&
               cur[4] == "P" && cur[5] == ")")
        op_next.kind = scpc_pkg::RSP_STOP;
      else if (cur[0] == "(" && cur[1] == "M" && cur[2] == "1" && cur[3] == ")")
        op_next.kind = scpc_pkg::RSP_M1;
      else begin
        if (cur[0] == "(" && cur[1] == "M" && cur[2] == "2" && cur[3] == ":") begin
          if (cur[5] == scpc_pkg::CH_CLOSE) len = 2'd1;
          else if (cur[6] == scpc_pkg::CH_CLOSE) len = 2'd2;
          else if (cur[7] == scpc_pkg::CH_CLOSE) len = 2'd3;
        end
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < len) begin
            if (!is_dig(cur[4+i])) ok = 1'b0;
            val = 10'(val * 10'd10) + 10'(cur[4+i] - scpc_pkg::CH_ZERO);
          end
        end
        if (len == 2'd0 || !ok) op_next.kind = scpc_pkg::RSP_ERR;
        else if (val > 10'd255) op_next.kind = scpc_pkg::RSP_OVF;
        else begin
          op_next.kind  = scpc_pkg::RSP_M2;
          op_next.value = val[7:0];
        end
      end
    end
  end

  // line store and index update, a parse clears the first position
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      for (int i = 0; i < scpc_pkg::KEPT; i++) line[i] <= '0;
    end else if (accept && !func) begin
      for (int i = 0; i < scpc_pkg::KEPT; i++) begin
        if (i == 0 && rx_byte == scpc_pkg::CH_CLOSE) line[i] <= '0;
        else line[i] <= cur[i];
      end
      if (rx_byte == scpc_pkg::CH_CLOSE) begin
        write_index <= scpc_pkg::IDX_W'(1);
      end else if (widx == scpc_pkg::IDX_W'(scpc_pkg::LINE_LENGTH - 1)) begin
        write_index <= '0;
      end else begin
        write_index <= widx + 1'b1;
      end
    end
  end

  // request register toward the queue
  always_ff @(posedge clk) begin
    if (rst) op_valid <= 1'b0;
    else if (!op_stall) op_valid <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (accept) op <= op_next;
  end

endmodule

>>> hdl/scpc_queue.sv
// scpc_queue: two-entry queue between front and back
// depends on scpc_pkg
module scpc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_stall,
  input  scpc_pkg::scpc_op_t  wr_data,
  output logic                rd_valid,
  input  logic                rd_stall,
  output scpc_pkg::scpc_op_t  rd_data
);

  scpc_pkg::scpc_op_t slot [2];
  logic       rptr, wptr;
  logic [1:0] fill;
  logic       wr_go, rd_go;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = slot[rptr];
  assign wr_go    = wr_valid && !wr_stall;
  assign rd_go    = rd_valid && !rd_stall;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      rptr <= 1'b0;
      wptr <= 1'b0;
      fill <= '0;
    end else begin
      if (wr_go) wptr <= ~wptr;
      if (rd_go) rptr <= ~rptr;
      fill <= fill + {1'b0, wr_go} - {1'b0, rd_go};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_go) slot[wptr] <= wr_data;
  end

endmodule

>>> hdl/scpc_back.sv
// scpc_back: executes requests on the counter state and registers the result
// depends on scpc_pkg
module scpc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_stall,
  input  scpc_pkg::scpc_op_t  op,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          response,
  output logic                running,
  output logic                mode_two,
  output logic [7:0]          pulse_count,
  output logic [7:0]          shown_count,
  output logic [7:0]          command_value,
  output logic                error_seen
);

  logic       started, second_mode, last_pulse_level, sticky_error;
  logic [7:0] target_pulses, edge_count, display_count, issued_command;
  logic       go;

  assign op_stall = out_valid && out_stall;
  assign go       = op_valid && !op_stall;

  // state update and result register
  always_ff @(posedge clk) begin
    logic       s, m, l, e;
    logic [7:0] t, c, d, ic;
    if (rst) begin
      started <= 1'b0; second_mode <= 1'b0; last_pulse_level <= 1'b1;
      sticky_error <= 1'b0; target_pulses <= '0; edge_count <= '0;
      display_count <= '0; issued_command <= '0; out_valid <= 1'b0;
    end else begin
      if (!op_stall) out_valid <= op_valid;
      if (go) begin
        s = started; m = second_mode; l = last_pulse_level; e = sticky_error;
        t = target_pulses; c = edge_count; d = display_count; ic = issued_command;
        if (op.is_pin) begin
          if (s) begin
            if (!m) begin
              if (op.turn) begin
                if (l && !op.pulse) begin
                  c = c + 8'd1;
                  d = c;
                end
              end else c = '0;
            end else ic = t;
            l = op.pulse;
          end
        end else begin
          case (op.kind) inside
            scpc_pkg::RSP_START: begin s = 1'b1; m = 1'b0; end
            scpc_pkg::RSP_STOP:  begin s = 1'b0; c = '0; t = '0; end
            scpc_pkg::RSP_M1:    m = 1'b0;
            scpc_pkg::RSP_M2:    begin m = 1'b1; t = op.value; end
            scpc_pkg::RSP_ERR, scpc_pkg::RSP_OVF: e = 1'b1;
            default: ;
          endcase
        end
        started <= s; second_mode <= m; last_pulse_level <= l; sticky_error <= e;
        target_pulses <= t; edge_count <= c; display_count <= d; issued_command <= ic;
        response <= op.is_pin ? scpc_pkg::RSP_NONE : op.kind;
        running <= s; mode_two <= m; pulse_count <= c; shown_count <= d;
        command_value <= ic; error_seen <= e;
      end
    end
  end

endmodule

>>> hdl/serial_command_pulse_counter_top.sv
// serial_command_pulse_counter_top: parser front, request queue, counter back
// depends on scpc_pkg, scpc_front, scpc_queue, scpc_back
// One request per cycle while no stall is raised: a byte or pin sample is parsed
// in the front stage (fixed buffer positions), sits in a two-entry queue, and
// the back stage updates the counter state and registers one result per request.
// A request passes the front request register, a queue slot and the result register.
module serial_command_pulse_counter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] rx_byte,
  input  logic       pulse_pin,
  input  logic       turn_pin,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] response,
  output logic       running,
  output logic       mode_two,
  output logic [7:0] pulse_count,
  output logic [7:0] shown_count,
  output logic [7:0] command_value,
  output logic       error_seen
);

  scpc_pkg::scpc_op_t f_op, q_op;
  logic f_valid, f_stall, q_valid, q_stall;

  scpc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .rx_byte, .pulse_pin, .turn_pin,
    .op_valid(f_valid), .op_stall(f_stall), .op(f_op)
  );

  scpc_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_op),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_op)
  );

  scpc_back u_back (
    .clk, .rst, .op_valid(q_valid), .op_stall(q_stall), .op(q_op),
    .out_valid, .out_stall, .response, .running, .mode_two, .pulse_count,
    .shown_count, .command_value, .error_seen
  );

endmodule

>>> dv/serial_command_pulse_counter_top_tb.sv
// serial_command_pulse_counter_top_tb: self-checking bench for the serial command pulse counter
// depends on scpc_pkg and serial_command_pulse_counter_top
module serial_command_pulse_counter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] response;
    logic       running;
    logic       mode_two;
    logic [7:0] pulse_count;
    logic [7:0] shown_count;
    logic [7:0] command_value;
    logic       error_seen;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = 1'b0;
  logic [7:0] rx_byte = 8'd0;
  logic pulse_pin = 1'b0;
  logic turn_pin = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] response;
  logic running, mode_two, error_seen;
  logic [7:0] pulse_count, shown_count, command_value;

  serial_command_pulse_counter_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .rx_byte(rx_byte), .pulse_pin(pulse_pin), .turn_pin(turn_pin),
    .out_valid(out_valid), .out_stall(out_stall), .response(response),
    .running(running), .mode_two(mode_two), .pulse_count(pulse_count),
    .shown_count(shown_count), .command_value(command_value), .error_seen(error_seen)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [7:0] line_buf [scpc_pkg::KEPT];
  logic [scpc_pkg::IDX_W-1:0] wr_idx;
  logic run_q, mode2_q, last_pulse, err_q;
  logic [7:0] target_q, edges_q, display_q, issued_q;

  status_t expected_status [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  function automatic bit line_is(string s);
    for (int i = 0; i < s.len() && i < scpc_pkg::KEPT; i++)
      if (line_buf[i] != s[i]) return 0;
    return 1;
  endfunction

  // decode the buffered line and apply the command
  function automatic logic [2:0] decode_line();
    logic [2:0] rsp;
    int len;
    int val;
    bit ok;
    len = 0;
    val = 0;
    ok = 1;
    if (line_is("(START)")) begin
      run_q = 1; mode2_q = 0; rsp = scpc_pkg::RSP_START;
    end else if (line_is("(STOP)")) begin
      run_q = 0; edges_q = 0; target_q = 0; rsp = scpc_pkg::RSP_STOP;
    end else if (line_is("(M1)")) begin
      mode2_q = 0; rsp = scpc_pkg::RSP_M1;
    end else begin
      if (line_is("(M2:")) begin
        if (line_buf[5] == scpc_pkg::CH_CLOSE) len = 1;
        else if (line_buf[6] == scpc_pkg::CH_CLOSE) len = 2;
        else if (line_buf[7] == scpc_pkg::CH_CLOSE) len = 3;
      end
      if (len == 0) begin
        err_q = 1; rsp = scpc_pkg::RSP_ERR;
      end else begin
        for (int i = 0; i < len; i++) begin
          if (line_buf[4+i] < scpc_pkg::CH_ZERO || line_buf[4+i] > scpc_pkg::CH_ZERO + 9)
            ok = 0;
          else val = val * 10 + (line_buf[4+i] - scpc_pkg::CH_ZERO);
        end
        if (!ok) begin
          err_q = 1; rsp = scpc_pkg::RSP_ERR;
        end else if (val > 255) begin
          err_q = 1; rsp = scpc_pkg::RSP_OVF;
        end else begin
          mode2_q = 1; target_q = val[7:0]; rsp = scpc_pkg::RSP_M2;
        end
      end
    end
    line_buf[0] = 8'd0;
    wr_idx = 0;
    return rsp;
  endfunction

  task automatic reset_model();
    foreach (line_buf[i]) line_buf[i] = 8'd0;
    wr_idx = 0; run_q = 0; mode2_q = 0; target_q = 0; edges_q = 0;
    display_q = 0; issued_q = 0; last_pulse = 1; err_q = 0;
  endtask

  // advance the predictor by one request
  task automatic predict_status(logic f, logic [7:0] b, logic p, logic t);
    status_t s;
    s.response = scpc_pkg::RSP_NONE;
    if (!f) begin
      if (b == scpc_pkg::CH_OPEN) wr_idx = 0;
      if (wr_idx < scpc_pkg::KEPT) line_buf[wr_idx] = b;
      if (b == scpc_pkg::CH_CLOSE) s.response = decode_line();
      wr_idx = scpc_pkg::IDX_W'((wr_idx + 1) % scpc_pkg::LINE_LENGTH);
    end else if (run_q) begin
      if (!mode2_q) begin
        if (t) begin
          if (last_pulse && !p) begin
            edges_q = 8'(edges_q + 1);
            display_q = edges_q;
          end
        end else edges_q = 0;
      end else issued_q = target_q;
      last_pulse = p;
    end
    s.running = run_q; s.mode_two = mode2_q; s.pulse_count = edges_q;
    s.shown_count = display_q; s.command_value = issued_q; s.error_seen = err_q;
    expected_status.push_back(s);
  endtask

  // drive one request and wait for acceptance, valid stays up for the next one
  task automatic send_request(logic f, logic [7:0] b, logic p, logic t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; func <= f; rx_byte <= b; pulse_pin <= p; turn_pin <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_status(f, b, p, t);
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_request(1'b0, s[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic pin_tick(int p, int t);
    send_request(1'b1, 8'($urandom_range(255)), 1'(p), 1'(t));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    status_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {response, running, mode_two, pulse_count, shown_count, command_value,
             error_seen};
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_status.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected rsp=%0d run=%b m2=%b cnt=%0d shown=%0d cmd=%0d err=%b, got rsp=%0d run=%b m2=%b cnt=%0d shown=%0d cmd=%0d err=%b",
              want.response, want.running, want.mode_two, want.pulse_count,
              want.shown_count, want.command_value, want.error_seen,
              got.response, got.running, got.mode_two, got.pulse_count,
              got.shown_count, got.command_value, got.error_seen);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // every command, digit forms, errors, edge counting and buffer overrun
  task automatic test_directed();
    send_text("(START)");
    pin_tick(1, 1); pin_tick(0, 1); pin_tick(1, 1); pin_tick(0, 1);
    pin_tick(0, 0);
    send_text("(M2:7)"); pin_tick(1, 0);
    send_text("(M2:42)"); send_text("(M2:255)"); pin_tick(0, 1);
    send_text("(M2:256)");
    send_text("(M2:9x)");
    send_text("(M1)");
    send_text("(ABCDEFGHIJKLMNOPQRSTUVW)");
    send_request(1'b0, 8'hff, 1'b1, 1'b1); send_request(1'b0, 8'h00, 1'b0, 1'b0);
    send_text("(STOP)"); pin_tick(0, 1);
  endtask

  // random command lines, noise and pin ticks
  task automatic test_random(int n);
    string cmds [6] = '{"(START)", "(STOP)", "(M1)", "(M2:", "(M2:", "(X"};
    string s;
    int k;
    logic [7:0] ch;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) pin_tick($urandom_range(1), int'($urandom_range(9) != 0));
      else if (k < 90) begin
        s = cmds[$urandom_range(5)];
        if (s == "(M2:") begin
          repeat ($urandom_range(1, 4)) begin
            ch = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                          : 8'(scpc_pkg::CH_ZERO + $urandom_range(9));
            s = {s, string'(ch)};
          end
          s = {s, ")"};
        end
        send_text(s);
        i += s.len() - 1;
      end else send_request(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
    end
  endtask

  // long receiver hold-off so the block backs up
  task automatic test_backpressure();
    hold_cycles = 60;
    test_random(40);
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    drain();
    send_idle_pct = 0;  stall_pct = 0;  test_random(500);
    send_idle_pct = 80; stall_pct = 0;  test_random(350);
    send_idle_pct = 0;  stall_pct = 80; test_random(350);
    send_idle_pct = 34; stall_pct = 34; test_random(350);
    send_idle_pct = 0;  stall_pct = 0;  test_backpressure();
    drain();
    if (mismatches == 0 && expected_status.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

>>> files.f
hdl/scpc_pkg.sv
hdl/scpc_front.sv
hdl/scpc_queue.sv
hdl/scpc_back.sv
hdl/serial_command_pulse_counter_top.sv
dv/serial_command_pulse_counter_top_tb.sv
